[rtl/fgt_pkg.sv]
// ----------------------------------------------------------------------------
// fgt_pkg: shared types and constants for the frost guard thermostat
// Register indexes, reset values, field types and the divide-by-ten
// reciprocal used by the rounding stage.
// ----------------------------------------------------------------------------
package fgt_pkg;

	// Field widths
	localparam int TEMP_W  = 16;
	localparam int WHOLE_W = 13;
	localparam int REG_W   = 8;
	localparam int IDX_W   = 2;

	typedef logic signed [TEMP_W-1:0]  temp_t;
	typedef logic signed [WHOLE_W-1:0] whole_t;
	typedef logic signed [REG_W-1:0]   thr_t;
	typedef logic [REG_W-1:0]          count_t;

	// Register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_TEMP_ON     = 2'd0,
		REG_TEMP_OFF    = 2'd1,
		REG_TEMP_FREEZE = 2'd2,
		REG_FAIL_LIMIT  = 2'd3
	} reg_idx_t;

	// Register reset values
	localparam thr_t   TEMP_ON_RST     = 8'sd8;
	localparam thr_t   TEMP_OFF_RST    = 8'sd9;
	localparam thr_t   TEMP_FREEZE_RST = -8'sd10;
	localparam count_t FAIL_LIMIT_RST  = 8'd60;

	// Readings below this value are sensor error codes
	localparam temp_t  ERR_BELOW = -16'sd32513;

	// Error counter saturation
	localparam count_t COUNT_MAX = 8'hFF;

	// Rounding: add half a degree, then multiply by 2^19/10 rounded up.
	// Exact for every 16-bit unsigned dividend used here.
	localparam logic [TEMP_W-1:0] HALF_DEG   = 16'd5;
	localparam logic [15:0]       RECIP_TEN  = 16'd52429;
	localparam int                RECIP_SHFT = 19;

	// Configuration seen by the datapath
	typedef struct packed {
		thr_t   temp_on;
		thr_t   temp_off;
		thr_t   temp_freeze;
		count_t fail_limit;
	} cfg_t;

endpackage

[rtl/fgt_if.sv]
// ----------------------------------------------------------------------------
// fgt_if: valid/ready channels of the frost guard thermostat
// One channel for incoming readings, one for results.
// ----------------------------------------------------------------------------
interface fgt_in_if
	import fgt_pkg::*;
();
	logic  valid;
	logic  ready;
	temp_t temp_tenths;

	modport source (output valid, output temp_tenths, input ready);
	modport sink   (input valid, input temp_tenths, output ready);
endinterface

interface fgt_out_if
	import fgt_pkg::*;
();
	logic       valid;
	logic       ready;
	logic       relay_on;
	logic       freeze_alarm;
	logic       sensor_error;
	logic       emergency_off;
	logic [7:0] error_code;
	whole_t     whole_degrees;

	modport source (
		output valid, output relay_on, output freeze_alarm, output sensor_error,
		output emergency_off, output error_code, output whole_degrees,
		input ready
	);
	modport sink (
		input valid, input relay_on, input freeze_alarm, input sensor_error,
		input emergency_off, input error_code, input whole_degrees,
		output ready
	);
endinterface

[rtl/fgt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// fgt_cfg_regs: configuration register file
// Four 8-bit registers written through a plain write port.
// ----------------------------------------------------------------------------
module fgt_cfg_regs
	import fgt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// Decode the index and update one register per write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_on     <= TEMP_ON_RST;
			cfg_q.temp_off    <= TEMP_OFF_RST;
			cfg_q.temp_freeze <= TEMP_FREEZE_RST;
			cfg_q.fail_limit  <= FAIL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TEMP_ON:     cfg_q.temp_on     <= thr_t'(cfg_data);
				REG_TEMP_OFF:    cfg_q.temp_off    <= thr_t'(cfg_data);
				REG_TEMP_FREEZE: cfg_q.temp_freeze <= thr_t'(cfg_data);
				REG_FAIL_LIMIT:  cfg_q.fail_limit  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/fgt_round.sv]
// ----------------------------------------------------------------------------
// fgt_round: tenths of a degree to whole degrees
// Truncating divide by ten; non-negative readings round half up, negative
// readings round toward zero. One reciprocal multiply, no divider.
// ----------------------------------------------------------------------------
module fgt_round
	import fgt_pkg::*;
(
	input  temp_t  temp_tenths,
	output whole_t whole
);

	logic              neg;
	logic [TEMP_W-1:0] mag;
	logic [TEMP_W-1:0] dividend;
	logic [31:0]       prod;
	logic [WHOLE_W-1:0] quot;

	// Take the magnitude; add the half degree only on the positive side
	assign neg      = temp_tenths[TEMP_W-1];
	assign mag      = neg ? (~temp_tenths + 16'd1) : temp_tenths;
	assign dividend = neg ? mag : (mag + HALF_DEG);

	// Multiply by the reciprocal and keep the integer part
	assign prod = 32'(dividend) * 32'(RECIP_TEN);
	assign quot = prod[RECIP_SHFT +: WHOLE_W];

	// Restore the sign
	assign whole = neg ? whole_t'(-$signed(quot)) : whole_t'($signed(quot));

endmodule

[rtl/frost_guard_thermostat.sv]
// ----------------------------------------------------------------------------
// frost_guard_thermostat: hysteresis heater control with frost protection
// Rounds each reading to whole degrees, drives the relay through freeze,
// off and on thresholds, and forces the relay off after too many
// consecutive sensor errors.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat payload                               handshake
//  reading   in   temp_tenths                                valid/ready
//  result    out  relay_on, freeze_alarm, sensor_error,      valid/ready
//                 emergency_off, error_code, whole_degrees
//  cfg       in   cfg_index, cfg_data                        cfg_we only
//
//  One reading per cycle while the result channel does not stall; each
//  beat passes an input register, then the rounding multiply and threshold
//  compares, then the result register, from which its result is offered.
//  Relay state and error counter update as a beat moves into the result
//  register. Reset restores the register defaults and clears relay and
//  counter. A stalled result holds, and one more reading is taken into the
//  input register behind it.
//
module frost_guard_thermostat
	import fgt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data,
	fgt_in_if.sink           reading,
	fgt_out_if.source        result
);

	cfg_t   cfg;
	whole_t whole;

	logic   valid_s1;
	temp_t  temp_s1;
	logic   advance;

	logic   relay_q;
	count_t fail_count_q;

	logic   is_err;
	logic   relay_nxt;
	count_t count_nxt;
	logic   alarm_nxt;
	logic   emerg_nxt;

	logic       valid_s2;
	logic       relay_s2;
	logic       alarm_s2;
	logic       err_s2;
	logic       emerg_s2;
	logic [7:0] code_s2;
	whole_t     whole_s2;

	fgt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fgt_round u_round (
		.temp_tenths (temp_s1),
		.whole       (whole)
	);

	// Move a beat on when the result register is free or being drained
	assign advance       = valid_s1 && (!valid_s2 || result.ready);
	assign reading.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (reading.valid && reading.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (reading.valid && reading.ready) begin
			temp_s1 <= reading.temp_tenths;
		end
	end

	// Relay and error counter rule
	assign is_err = temp_s1 < ERR_BELOW;

	always_comb begin
		relay_nxt = relay_q;
		count_nxt = fail_count_q;
		alarm_nxt = 1'b0;
		emerg_nxt = 1'b0;
		if (is_err) begin
			if (fail_count_q > cfg.fail_limit) begin
				relay_nxt = 1'b0;
				emerg_nxt = 1'b1;
			end else if (fail_count_q != COUNT_MAX) begin
				count_nxt = fail_count_q + 8'd1;
			end
		end else begin
			count_nxt = '0;
			if (whole <= WHOLE_W'(cfg.temp_freeze)) begin
				relay_nxt = 1'b0;
				alarm_nxt = 1'b1;
			end else if (whole >= WHOLE_W'(cfg.temp_off)) begin
				relay_nxt = 1'b0;
			end else if (whole <= WHOLE_W'(cfg.temp_on)) begin
				relay_nxt = 1'b1;
			end
		end
	end

	// Commit state as the beat leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q      <= 1'b0;
			fail_count_q <= '0;
		end else if (advance) begin
			relay_q      <= relay_nxt;
			fail_count_q <= count_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			relay_s2 <= relay_nxt;
			alarm_s2 <= alarm_nxt;
			err_s2   <= is_err;
			emerg_s2 <= emerg_nxt;
			code_s2  <= is_err ? temp_s1[7:0] : 8'd0;
			whole_s2 <= is_err ? whole_t'(0) : whole;
		end
	end

	assign result.valid         = valid_s2;
	assign result.relay_on      = relay_s2;
	assign result.freeze_alarm  = alarm_s2;
	assign result.sensor_error  = err_s2;
	assign result.emergency_off = emerg_s2;
	assign result.error_code    = code_s2;
	assign result.whole_degrees = whole_s2;

endmodule

[verif/tb_frost_guard_thermostat.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frost_guard_thermostat: self-checking bench for the frost guard thermostat
// Walks a short directed plan of readings and register writes, then random
// phases under several threshold settings. A predictor tracks relay state and
// the error run, and every result beat is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_frost_guard_thermostat;
	import fgt_pkg::*;

	localparam int QUIET_LIMIT   = 1000;
	localparam int PRINT_LIMIT   = 40;
	localparam int PHASE_COUNT   = 10;
	localparam int PHASE_READS   = 16;
	localparam int SATURATE_RUN  = 258;

	typedef struct packed {
		logic       relay_on;
		logic       freeze_alarm;
		logic       sensor_error;
		logic       emergency_off;
		logic [7:0] error_code;
		whole_t     whole_degrees;
	} thermo_result_t;

	typedef struct packed {
		logic           is_write;
		reg_idx_t       idx;
		logic [7:0]     data;
		temp_t          temp;
		logic           typed;
		thermo_result_t want;
	} plan_row_t;

	typedef enum logic [1:0] {SINK_FLOW, SINK_COIN, SINK_PULSE, SINK_CHOKE} sink_mode_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_data;

	fgt_in_if  reading_ch();
	fgt_out_if result_ch();

	frost_guard_thermostat u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.reading   (reading_ch),
		.result    (result_ch)
	);

	// Predictor state and its copy of the registers
	cfg_t   cfg_model;
	logic   relay_model;
	count_t err_run;

	thermo_result_t pending_results[$];
	plan_row_t      directed_plan[$];

	bit             in_fire;
	bit             out_fire;
	bit             typed_row;
	thermo_result_t typed_want;
	int             burst_left;
	int             mismatch_count;
	int             quiet_cycles;
	sink_mode_t     sink_mode;
	int unsigned    sink_tick;

	always #5 clk = ~clk;

	// Advance the predictor by one reading and return the result it implies
	function automatic thermo_result_t heater_step(input temp_t t);
		thermo_result_t r;
		int tv;
		int deg;
		r = '0;
		tv = int'(t);
		deg = 0;
		if (t < ERR_BELOW) begin
			r.sensor_error = 1'b1;
			r.error_code = t[7:0];
			if (err_run > cfg_model.fail_limit) begin
				relay_model = 1'b0;
				r.emergency_off = 1'b1;
			end else if (err_run != COUNT_MAX) begin
				err_run = err_run + 1'b1;
			end
		end else begin
			// truncating divide, then bump on a remainder of half a degree or more
			deg = tv / 10 + ((tv % 10 >= 5) ? 1 : 0);
			err_run = '0;
			if (deg <= int'(cfg_model.temp_freeze)) begin
				relay_model = 1'b0;
				r.freeze_alarm = 1'b1;
			end else if (deg >= int'(cfg_model.temp_off)) begin
				relay_model = 1'b0;
			end else if (deg <= int'(cfg_model.temp_on)) begin
				relay_model = 1'b1;
			end
		end
		r.relay_on = relay_model;
		r.whole_degrees = deg[WHOLE_W-1:0];
		return r;
	endfunction

	function automatic plan_row_t rd(input int t);
		plan_row_t row;
		row = '0;
		row.temp = t[TEMP_W-1:0];
		return row;
	endfunction

	function automatic plan_row_t rd_exp(input int t, input bit relay, input bit alarm,
			input bit err, input bit emerg, input logic [7:0] code, input int whole);
		plan_row_t row;
		row = rd(t);
		row.typed = 1'b1;
		row.want = '{relay, alarm, err, emerg, code, whole[WHOLE_W-1:0]};
		return row;
	endfunction

	function automatic plan_row_t wr(input reg_idx_t idx, input logic [7:0] data);
		plan_row_t row;
		row = '0;
		row.is_write = 1'b1;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	// Error codes span -32768 .. -32514
	function automatic temp_t rand_error();
		int v;
		v = -32768 + int'($urandom_range(0, 254));
		return v[TEMP_W-1:0];
	endfunction

	task automatic flag_mismatch(input string what, input thermo_result_t got,
			input thermo_result_t want);
		string got_s;
		string want_s;
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			got_s = $sformatf("got relay=%0b alarm=%0b err=%0b emerg=%0b code=%02h deg=%0d",
				got.relay_on, got.freeze_alarm, got.sensor_error,
				got.emergency_off, got.error_code, $signed(got.whole_degrees));
			want_s = $sformatf("want relay=%0b alarm=%0b err=%0b emerg=%0b code=%02h deg=%0d",
				want.relay_on, want.freeze_alarm, want.sensor_error,
				want.emergency_off, want.error_code, $signed(want.whole_degrees));
			$display("[%0t] %s: %s | %s", $realtime, what, got_s, want_s);
		end
	endtask

	// Offer one reading; bursts of random length with random gaps between them
	task automatic send_reading(input temp_t t, input bit typed, input thermo_result_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				reading_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		typed_row = typed;
		typed_want = want;
		reading_ch.valid <= 1'b1;
		reading_ch.temp_tenths <= t;
		do @(posedge clk); while (!in_fire);
		burst_left--;
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic settle();
		reading_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TEMP_ON:     cfg_model.temp_on = val;
			REG_TEMP_OFF:    cfg_model.temp_off = val;
			REG_TEMP_FREEZE: cfg_model.temp_freeze = val;
			REG_FAIL_LIMIT:  cfg_model.fail_limit = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_thresholds(input int on_deg, input int off_deg, input int frz_deg,
			input int limit);
		settle();
		write_reg(REG_TEMP_ON, on_deg[7:0]);
		write_reg(REG_TEMP_OFF, off_deg[7:0]);
		write_reg(REG_TEMP_FREEZE, frz_deg[7:0]);
		write_reg(REG_FAIL_LIMIT, limit[7:0]);
	endtask

	// Sample both channels mid-cycle; a beat seen here moves at the next rising edge
	always @(negedge clk) begin : beat_monitor
		thermo_result_t want;
		thermo_result_t got;
		in_fire = arst_n && reading_ch.valid && reading_ch.ready;
		out_fire = arst_n && result_ch.valid && result_ch.ready;
		if (in_fire) begin
			want = heater_step(reading_ch.temp_tenths);
			if (typed_row)
				want = typed_want;
			pending_results.push_back(want);
		end
		if (out_fire) begin
			got.relay_on = result_ch.relay_on;
			got.freeze_alarm = result_ch.freeze_alarm;
			got.sensor_error = result_ch.sensor_error;
			got.emergency_off = result_ch.emergency_off;
			got.error_code = result_ch.error_code;
			got.whole_degrees = result_ch.whole_degrees;
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result", got, '0);
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					flag_mismatch("result mismatch", got, want);
			end
		end
	end

	// Result sink: switch between randomly chosen stall patterns
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			sink_tick <= 0;
			sink_mode <= SINK_FLOW;
		end else begin
			sink_tick <= sink_tick + 1;
			if (sink_tick % 60 == 59)
				sink_mode <= sink_mode_t'($urandom_range(0, 3));
			case (sink_mode)
				SINK_FLOW:  result_ch.ready <= 1'b1;
				SINK_COIN:  result_ch.ready <= ($urandom_range(0, 2) != 0);
				SINK_PULSE: result_ch.ready <= (sink_tick % 3 == 0);
				default:    result_ch.ready <= (sink_tick % 16 < 3);
			endcase
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || in_fire || out_fire) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int ph;
		int sent;
		int pick;
		int burst;
		int thr;
		int t_val;
		int on_deg;
		int lim;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TEMP_ON;
		cfg_data = '0;
		reading_ch.valid = 1'b0;
		reading_ch.temp_tenths = '0;
		result_ch.ready = 1'b0;
		cfg_model = '{TEMP_ON_RST, TEMP_OFF_RST, TEMP_FREEZE_RST, FAIL_LIMIT_RST};
		relay_model = 1'b0;
		err_run = '0;
		burst_left = 0;
		mismatch_count = 0;
		typed_row = 1'b0;
		typed_want = '0;

		directed_plan = '{
			// extremes of the reading at reset thresholds
			rd_exp(32767, 0, 0, 0, 0, 8'h00, 3277),
			rd_exp(-32513, 0, 1, 0, 0, 8'h00, -3251),
			rd_exp(-32514, 0, 0, 1, 0, 8'hFE, 0),
			rd_exp(-32768, 0, 0, 1, 0, 8'h00, 0),
			// hysteresis edges
			rd_exp(80, 1, 0, 0, 0, 8'h00, 8),
			rd_exp(85, 0, 0, 0, 0, 8'h00, 9),
			rd_exp(84, 1, 0, 0, 0, 8'h00, 8),
			// negative readings round toward zero, non-negative ones round half up
			rd(-15), rd(-5), rd(4), rd(5), rd(86),
			rd_exp(-100, 0, 1, 0, 0, 8'h00, -10),
			rd(-95), rd(-105),
			rd(21845), rd(-21846),
			// emergency off with no tolerance
			wr(REG_FAIL_LIMIT, 8'd0),
			rd(0), rd(-32600), rd(-32514), rd(-32700),
			// inverted thresholds: priority order decides
			wr(REG_TEMP_ON, 8'h7F), wr(REG_TEMP_OFF, 8'h80), wr(REG_TEMP_FREEZE, 8'h80),
			rd(0), rd(-32513)
		};

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan
		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_write) begin
				settle();
				write_reg(directed_plan[i].idx, directed_plan[i].data);
			end else begin
				send_reading(directed_plan[i].temp, directed_plan[i].typed,
					directed_plan[i].want);
			end
		end

		// Drive the error counter into saturation, then lower the limit under it
		load_thresholds(20, 25, -30, 255);
		send_reading(16'sd200, 1'b0, '0);
		repeat (SATURATE_RUN) send_reading(rand_error(), 1'b0, '0);
		settle();
		write_reg(REG_FAIL_LIMIT, 8'd10);
		repeat (2) send_reading(rand_error(), 1'b0, '0);
		send_reading(16'sd100, 1'b0, '0);

		// Random phases
		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: load_thresholds(8, 9, -10, 60);
				1: load_thresholds(127, 127, -128, 255);
				2: load_thresholds(-128, -128, 127, 0);
				3: load_thresholds(-128, 127, -128, 1);
				default: begin
					on_deg = int'($urandom_range(0, 80)) - 40;
					lim = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
						: int'($urandom_range(0, 4));
					load_thresholds(on_deg, on_deg + int'($urandom_range(1, 6)),
						on_deg - int'($urandom_range(1, 25)), lim);
				end
			endcase
			sent = 0;
			while (sent < PHASE_READS) begin
				pick = $urandom_range(0, 99);
				if (pick < 20) begin
					// run of sensor errors, long enough to trip small limits
					burst = $urandom_range(1, (cfg_model.fail_limit < 8)
						? cfg_model.fail_limit + 3 : 6);
					repeat (burst) begin
						send_reading(rand_error(), 1'b0, '0);
						sent++;
					end
				end else if (pick < 70) begin
					case ($urandom_range(0, 2))
						0: thr = int'(cfg_model.temp_on);
						1: thr = int'(cfg_model.temp_off);
						default: thr = int'(cfg_model.temp_freeze);
					endcase
					t_val = thr * 10 + int'($urandom_range(0, 40)) - 20;
					send_reading(t_val[TEMP_W-1:0], 1'b0, '0);
					sent++;
				end else if (pick < 88) begin
					t_val = $urandom_range(0, 65535);
					send_reading(t_val[TEMP_W-1:0], 1'b0, '0);
					sent++;
				end else begin
					t_val = int'($urandom_range(0, 30)) - 15;
					send_reading(t_val[TEMP_W-1:0], 1'b0, '0);
					sent++;
				end
			end
		end

		settle();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
